// ===== hdl/vadpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// vadpcm_pkg: shared types and helpers for the ADPCM frame decoder
// Item structs, item kinds, sequencer states and the residual expander.
// ----------------------------------------------------------------------------
package vadpcm_pkg;

   localparam int unsigned GROUP_SAMPLES  = 8;
   localparam int unsigned CODEBOOK_DEPTH = 256;
   localparam int unsigned COEF_WIDTH     = 16;
   localparam int unsigned CSR_WIDTH      = 5;
   localparam logic [4:0]  MAX_PREDICTORS = 5'd16;

   localparam logic [0:0] CSR_PREDICTOR_COUNT = 1'b0;
   localparam logic [0:0] CSR_HALF_MODE       = 1'b1;

   typedef enum logic [1:0] {
      KIND_FRAME_BYTE = 2'd0,
      KIND_COEF_WRITE = 2'd1,
      KIND_START      = 2'd2,
      KIND_UNUSED     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CALC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         data_byte;
      logic [7:0]         coef_index;
      logic signed [15:0] coef_value;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               clipped;
      logic               last_of_run;
   } rsp_data_type;

   // Shift the code up by the scale inside 16 bits, then sign-extend from
   // the top code bit (capped at bit 15).
   function automatic logic signed [15:0] make_residual(
      input logic [3:0] code,
      input logic       half,
      input logic [3:0] scale
   );
      logic [15:0] sh;
      logic [4:0]  sp;
      logic [15:0] r;
      sh = (half ? {14'd0, code[1:0]} : {12'd0, code}) << scale;
      sp = {1'b0, scale} + (half ? 5'd1 : 5'd3);
      if (sp > 5'd15) begin
         sp = 5'd15;
      end
      for (int b = 0; b < 16; b++) begin
         r[b] = (5'(b) <= sp) ? sh[b] : sh[sp[3:0]];
      end
      return signed'(r);
   endfunction

endpackage

// ===== hdl/vadpcm_ram.sv =====
// ----------------------------------------------------------------------------
// vadpcm_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data appears next cycle.
// ----------------------------------------------------------------------------
module vadpcm_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/vadpcm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// vadpcm_frame_decoder: order-2 predictive ADPCM frame decoder
// Header, payload and codebook items in; saturated 16-bit samples out.
// ----------------------------------------------------------------------------
// Sequence: sample i of a group (0..7) accumulates i+2 MAC terms, then drains
//   the pipeline and waits in the output register for rsp_ready.
// Throughput: one item at a time; a payload byte holds the input until all
//   its 2 (or 4) samples are taken, longer under rsp_ready stalls; a header
//   holds it until the modulo is done.
// Reset: synchronous, active high; clears histories, residuals and frame state,
//   and sets config to its defaults; the codebook RAM keeps its contents.
module vadpcm_frame_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  vadpcm_pkg::req_data_type      req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output vadpcm_pkg::rsp_data_type      rsp_data,
   input  logic                          csr_write,
   input  logic [0:0]                    csr_index,
   input  logic [vadpcm_pkg::CSR_WIDTH-1:0] csr_data
);

   localparam int unsigned AW = $clog2(vadpcm_pkg::CODEBOOK_DEPTH);

   vadpcm_pkg::state_type state_ff, state_in;

   // configuration
   logic [4:0] pcount_ff, pcount_in;
   logic       half_ff, half_in;

   // frame state
   logic [3:0] pos_ff, pos_in;
   logic [3:0] scale_ff, scale_in;
   logic [3:0] pred_ff, pred_in;

   // stream history
   logic signed [15:0] hold_ff, hold_in;   // history_older
   logic signed [15:0] hnew_ff, hnew_in;   // history_newer
   logic signed [15:0] tail_ff, tail_in;   // sample 6 of this group
   logic signed [15:0] res_ff [8];
   logic signed [15:0] res_in [8];

   // sequencer
   logic [1:0] k_ff, k_in;      // sample within this byte
   logic [2:0] first_ff, first_in;
   logic [3:0] j_ff, j_in;      // MAC term

   // MAC pipeline
   logic               issue_ff, issue_in;
   logic               mul_ff, mul_in;
   logic signed [15:0] opb_ff, opb_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [35:0] acc_ff, acc_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   vadpcm_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   // codebook port
   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [15:0]   ram_rdata;

   // combinational helpers
   logic       accept;
   logic [3:0] len;
   logic [1:0] last_k;
   logic [4:0] cnt;
   logic [2:0] cur_i;
   logic [2:0] rsel;
   logic [2:0] tap_x;
   logic signed [15:0] res_sel;
   logic signed [24:0] quot;
   logic signed [15:0] sat;
   logic               clip;

   vadpcm_ram #(
      .WIDTH (vadpcm_pkg::COEF_WIDTH),
      .DEPTH (vadpcm_pkg::CODEBOOK_DEPTH)
   ) u_codebook (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_data.coef_index),
      .wr_data (req_data.coef_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == vadpcm_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign ram_we    = accept && (req_data.kind == vadpcm_pkg::KIND_COEF_WRITE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign len    = half_ff ? 4'd4 : 4'd8;
   assign last_k = half_ff ? 2'd3 : 2'd1;
   assign cur_i  = first_ff + {1'b0, k_ff};
   assign tap_x  = 3'(j_ff - 4'd2);
   // one residual read per cycle: own residual on term 0, older ones after
   assign rsel    = (j_ff <= 4'd1) ? cur_i : 3'(4'(cur_i) + 4'd1 - j_ff);
   assign res_sel = res_ff[rsel];

   always_comb begin
      if (pcount_ff == 5'd0) begin
         cnt = 5'd1;
      end else if (pcount_ff > vadpcm_pkg::MAX_PREDICTORS) begin
         cnt = vadpcm_pkg::MAX_PREDICTORS;
      end else begin
         cnt = pcount_ff;
      end
   end

   // codebook address of term j: c1[i], c2[i], then c2[x] for x < i
   always_comb begin
      if (j_ff == 4'd0) begin
         ram_raddr = {pred_ff, 1'b0, cur_i};
      end else if (j_ff == 4'd1) begin
         ram_raddr = {pred_ff, 1'b1, cur_i};
      end else begin
         ram_raddr = {pred_ff, 1'b1, tap_x};
      end
   end

   // floor shift by 11 and saturate
   always_comb begin
      quot = acc_ff[35:11];
      clip = 1'b0;
      if (quot > 25'sd32767) begin
         sat  = 16'sh7fff;
         clip = 1'b1;
      end else if (quot < -25'sd32768) begin
         sat  = -16'sh8000;
         clip = 1'b1;
      end else begin
         sat = quot[15:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      pcount_in    = pcount_ff;
      half_in      = half_ff;
      pos_in       = pos_ff;
      scale_in     = scale_ff;
      pred_in      = pred_ff;
      hold_in      = hold_ff;
      hnew_in      = hnew_ff;
      tail_in      = tail_ff;
      res_in       = res_ff;
      k_in         = k_ff;
      first_in     = first_ff;
      j_in         = j_ff;
      issue_in     = 1'b0;
      mul_in       = issue_ff;
      opb_in       = opb_ff;
      prod_in      = signed'(ram_rdata) * opb_ff;
      acc_in       = mul_ff ? acc_ff + 36'(prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         vadpcm_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  vadpcm_pkg::KIND_START: begin
                     hold_in  = '0;
                     hnew_in  = '0;
                     tail_in  = '0;
                     pos_in   = '0;
                     scale_in = '0;
                     pred_in  = '0;
                     for (int n = 0; n < 8; n++) begin
                        res_in[n] = '0;
                     end
                  end
                  vadpcm_pkg::KIND_FRAME_BYTE: begin
                     if (pos_ff == 4'd0 || pos_ff > len) begin
                        // header: scale, then reduce predictor by repeated subtract
                        scale_in = req_data.data_byte[7:4];
                        pred_in  = req_data.data_byte[3:0];
                        pos_in   = 4'd1;
                        state_in = vadpcm_pkg::ST_MOD;
                     end else begin
                        first_in = half_ff ? 3'({pos_ff - 4'd1, 2'b00})
                                           : 3'({pos_ff - 4'd1, 1'b0});
                        for (int n = 0; n < 4; n++) begin
                           if (half_ff) begin
                              res_in[3'(first_in + 3'(n))] = vadpcm_pkg::make_residual(
                                 {2'b00, req_data.data_byte[7 - 2*n -: 2]},
                                 1'b1, scale_ff);
                           end else if (n < 2) begin
                              res_in[3'(first_in + 3'(n))] = vadpcm_pkg::make_residual(
                                 req_data.data_byte[7 - 4*n -: 4], 1'b0, scale_ff);
                           end
                        end
                        k_in     = '0;
                        j_in     = '0;
                        state_in = vadpcm_pkg::ST_CALC;
                     end
                  end
                  default: begin
                     // codebook writes go straight to the RAM; drop unused kind
                  end
               endcase
            end
         end
         vadpcm_pkg::ST_MOD: begin
            if ({1'b0, pred_ff} >= cnt) begin
               pred_in = 4'({1'b0, pred_ff} - cnt);
            end else begin
               state_in = vadpcm_pkg::ST_IDLE;
            end
         end
         vadpcm_pkg::ST_CALC: begin
            issue_in = 1'b1;
            if (j_ff == 4'd0) begin
               opb_in = hold_ff;
               acc_in = 36'(signed'({res_sel, 11'd0}));
            end else if (j_ff == 4'd1) begin
               opb_in = hnew_ff;
            end else begin
               opb_in = res_sel;
            end
            j_in = j_ff + 4'd1;
            if (j_ff == 4'(cur_i) + 4'd1) begin
               state_in = vadpcm_pkg::ST_DRAIN;
            end
         end
         vadpcm_pkg::ST_DRAIN: begin
            if (!issue_ff && !mul_ff) begin
               rsp_data_in.sample      = sat;
               rsp_data_in.clipped     = clip;
               rsp_data_in.last_of_run = (k_ff == last_k);
               rsp_valid_in            = 1'b1;
               if (cur_i == 3'd6) begin
                  tail_in = sat;
               end
               if (cur_i == 3'd7) begin
                  hold_in = tail_ff;
                  hnew_in = sat;
               end
               state_in = vadpcm_pkg::ST_OUT;
            end
         end
         vadpcm_pkg::ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (k_ff == last_k) begin
                  pos_in   = (pos_ff >= len) ? 4'd0 : pos_ff + 4'd1;
                  state_in = vadpcm_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  j_in     = '0;
                  state_in = vadpcm_pkg::ST_CALC;
               end
            end
         end
         default: begin
            state_in = vadpcm_pkg::ST_IDLE;
         end
      endcase

      // user writes config only when idle (unchecked); any write restarts frame
      if (csr_write) begin
         case (csr_index)
            vadpcm_pkg::CSR_PREDICTOR_COUNT: pcount_in = csr_data;
            vadpcm_pkg::CSR_HALF_MODE:       half_in   = csr_data[0];
            default: begin
            end
         endcase
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vadpcm_pkg::ST_IDLE;
         pcount_ff    <= 5'd1;
         half_ff      <= 1'b0;
         pos_ff       <= '0;
         scale_ff     <= '0;
         pred_ff      <= '0;
         hold_ff      <= '0;
         hnew_ff      <= '0;
         tail_ff      <= '0;
         for (int n = 0; n < 8; n++) begin
            res_ff[n] <= '0;
         end
         k_ff         <= '0;
         j_ff         <= '0;
         issue_ff     <= 1'b0;
         mul_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         half_ff      <= half_in;
         pos_ff       <= pos_in;
         scale_ff     <= scale_in;
         pred_ff      <= pred_in;
         hold_ff      <= hold_in;
         hnew_ff      <= hnew_in;
         tail_ff      <= tail_in;
         res_ff       <= res_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         issue_ff     <= issue_in;
         mul_ff       <= mul_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      opb_ff      <= opb_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/vadpcm_checker.sv =====
// ----------------------------------------------------------------------------
// vadpcm_checker: port-level checks for the ADPCM frame decoder
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module vadpcm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input vadpcm_pkg::rsp_data_type rsp_data
);

   // hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // no new request item while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while result pending");

   // reset leaves no result item behind
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a clipped sample sits at a rail
   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |->
         rsp_data.sample == 16'sh7fff || rsp_data.sample == -16'sh8000)
      else $error("clipped flag on in-range sample");

endmodule

bind vadpcm_frame_decoder vadpcm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_vadpcm_frame_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vadpcm_frame_decoder: self-checking bench for the ADPCM frame decoder
// Loads the codebook, walks a short table of directed items, then drives
// random frames under several register settings. A bit-accurate predictor
// works out every sample, and each result is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb_vadpcm_frame_decoder;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   vadpcm_pkg::req_data_type req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   vadpcm_pkg::rsp_data_type rsp_data;
   logic                     csr_write;
   logic [0:0]               csr_index;
   logic [vadpcm_pkg::CSR_WIDTH-1:0] csr_data;

   vadpcm_frame_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Cycles to let pass after the last sample before touching a register;
   // covers the slowest header (modulo) and a full sample pipeline.
   localparam int SETTLE_CYCLES = 80;

   // Coefficient sets loaded into the codebook; headers only pick these
   localparam int unsigned LOADED_PREDICTORS = 8;

   // Predictor state: decoder shadow copy
   logic signed [15:0] coef_rom [vadpcm_pkg::CODEBOOK_DEPTH];
   int          hist_older, hist_newer;
   int          residuals [vadpcm_pkg::GROUP_SAMPLES];
   int          tail_six;
   int unsigned frame_pos, frame_scale, frame_pred;
   logic [4:0]  cfg_count;
   logic        cfg_half;

   vadpcm_pkg::rsp_data_type pending_samples[$];
   int           mismatches;
   bit           steady;       // no idling on either side while set

   // Directed stimulus table
   typedef struct {
      vadpcm_pkg::kind_type kind;
      logic [7:0]         data_byte;
      logic [7:0]         coef_index;
      logic signed [15:0] coef_value;
      bit                 typed;        // expected sample given below
      logic signed [15:0] exp_sample;
      logic               exp_clipped;
   } directed_row_type;

   directed_row_type directed_rows [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on run length
   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

   // Sign-extend the low bits of v
   function automatic int sign_extend(int v, int bits);
      longint m;
      longint u;
      m = longint'(1) << (bits - 1);
      u = longint'(v) & ((m << 1) - 1);
      return int'((u ^ m) - m);
   endfunction

   function automatic int expand_code(int code, int nbits, int scale);
      int t;
      t = sign_extend((code << scale) & 32'hFFFF, 16);
      return sign_extend(t, scale + nbits);
   endfunction

   // Run sample i of the current group through the order-2 filter
   function automatic vadpcm_pkg::rsp_data_type filter_sample(int unsigned i);
      vadpcm_pkg::rsp_data_type r;
      longint acc;
      int unsigned base;
      int s;
      base = (frame_pred * 16) & 8'hFF;
      acc  = longint'(coef_rom[(base + i) & 8'hFF]) * hist_older;
      acc += longint'(coef_rom[(base + 8 + i) & 8'hFF]) * hist_newer;
      for (int x = 0; x < i; x++)
         acc += longint'(residuals[i - 1 - x]) * coef_rom[(base + 8 + x) & 8'hFF];
      acc += longint'(residuals[i]) * 2048;
      acc = acc >>> 11;
      r.clipped = 1'b1;
      if (acc > 32767) s = 32767;
      else if (acc < -32768) s = -32768;
      else begin
         s = int'(acc);
         r.clipped = 1'b0;
      end
      if (i == 6) tail_six = s;
      if (i == 7) begin
         hist_older = tail_six;
         hist_newer = s;
      end
      r.sample = 16'(s);
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Advance the shadow decoder by one accepted item and queue its samples
   task automatic decode_item(vadpcm_pkg::req_data_type it, bit typed,
                              logic signed [15:0] t_sample, logic t_clip);
      int unsigned len, per, first, cnt, code;
      vadpcm_pkg::rsp_data_type r;
      len = cfg_half ? 4 : 8;
      per = cfg_half ? 4 : 2;
      case (it.kind)
         vadpcm_pkg::KIND_COEF_WRITE: coef_rom[it.coef_index] = it.coef_value;
         vadpcm_pkg::KIND_START: begin
            hist_older = 0;
            hist_newer = 0;
            foreach (residuals[k]) residuals[k] = 0;
            tail_six = 0;
            frame_pos = 0;
            frame_scale = 0;
            frame_pred = 0;
         end
         vadpcm_pkg::KIND_FRAME_BYTE: begin
            if (frame_pos == 0 || frame_pos > len) begin
               cnt = cfg_count;
               if (cnt == 0) cnt = 1;
               if (cnt > vadpcm_pkg::MAX_PREDICTORS) cnt = vadpcm_pkg::MAX_PREDICTORS;
               frame_scale = it.data_byte >> 4;
               frame_pred = (it.data_byte & 4'hF) % cnt;
               frame_pos = 1;
            end else begin
               first = ((frame_pos - 1) * per) & (vadpcm_pkg::GROUP_SAMPLES - 1);
               for (int k = 0; k < per; k++) begin
                  if (cfg_half) code = (it.data_byte >> (6 - 2 * k)) & 3;
                  else code = sign_extend((it.data_byte >> (4 - 4 * k)) & 4'hF, 4);
                  residuals[(first + k) & 7] =
                     expand_code(code, cfg_half ? 2 : 4, frame_scale);
               end
               for (int k = 0; k < per; k++) begin
                  r = filter_sample((first + k) & 7);
                  r.last_of_run = (k == per - 1);
                  if (typed) begin
                     r.sample = t_sample;
                     r.clipped = t_clip;
                  end
                  pending_samples.push_back(r);
               end
               frame_pos = (frame_pos >= len) ? 0 : frame_pos + 1;
            end
         end
         default: ;   // unused kind: drop
      endcase
   endtask

   // Send one item: hold valid and payload until accepted, then predict
   task automatic send_item(vadpcm_pkg::req_data_type it, bit typed = 0,
                            logic signed [15:0] t_sample = 0, logic t_clip = 0);
      if (!steady && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      decode_item(it, typed, t_sample, t_clip);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [vadpcm_pkg::CSR_WIDTH-1:0] value);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == vadpcm_pkg::CSR_PREDICTOR_COUNT) cfg_count = value;
      else cfg_half = value[0];
      frame_pos = 0;
   endtask

   function automatic vadpcm_pkg::req_data_type frame_byte(logic [7:0] b);
      vadpcm_pkg::req_data_type it;
      it = '0;
      it.kind = vadpcm_pkg::KIND_FRAME_BYTE;
      it.data_byte = b;
      return it;
   endfunction

   // Random byte; where a header is due, its predictor lands on a loaded set
   function automatic logic [7:0] next_frame_byte();
      int unsigned cnt;
      int unsigned len;
      logic [3:0]  nib;
      len = cfg_half ? 4 : 8;
      if (frame_pos != 0 && frame_pos <= len) return 8'($urandom);
      cnt = cfg_count;
      if (cnt == 0) cnt = 1;
      if (cnt > vadpcm_pkg::MAX_PREDICTORS) cnt = vadpcm_pkg::MAX_PREDICTORS;
      nib = 4'($urandom);
      while ((nib % cnt) >= LOADED_PREDICTORS) nib = 4'($urandom);
      return {4'($urandom), nib};
   endfunction

   function automatic vadpcm_pkg::req_data_type random_noise();
      vadpcm_pkg::req_data_type it;
      it = vadpcm_pkg::req_data_type'(34'({$urandom, $urandom}));
      if (it.kind == vadpcm_pkg::KIND_FRAME_BYTE) it.kind = vadpcm_pkg::KIND_UNUSED;
      return it;
   endfunction

   // Result side: stall at random, check each sample against the oldest one
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 13);
   end

   always @(posedge clock) begin
      vadpcm_pkg::rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected sample %0d clipped %0b last %0b",
                        rsp_data.sample, rsp_data.clipped, rsp_data.last_of_run);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                           want.sample, want.clipped, want.last_of_run,
                           rsp_data.sample, rsp_data.clipped, rsp_data.last_of_run);
            end
         end
      end
   end

   task automatic add_row(vadpcm_pkg::kind_type k, logic [7:0] b, bit typed = 0,
                          logic signed [15:0] s = 0, logic c = 0,
                          logic [7:0] ci = 0, logic signed [15:0] cv = 0);
      directed_row_type row;
      row.kind = k;
      row.data_byte = b;
      row.coef_index = ci;
      row.coef_value = cv;
      row.typed = typed;
      row.exp_sample = s;
      row.exp_clipped = c;
      directed_rows.push_back(row);
   endtask

   // Random frames: mostly whole frames, some restarts, noise and cut-short frames
   task automatic random_phase(int n_items);
      int sent;
      int len;
      int cut;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 19))
            0: begin
               send_item(vadpcm_pkg::req_data_type'({vadpcm_pkg::KIND_START,
                                                     32'($urandom)}));
               sent++;
            end
            1, 2: begin
               send_item(random_noise());
               sent++;
            end
            default: begin
               len = cfg_half ? 4 : 8;
               cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
               send_item(frame_byte(next_frame_byte()));
               for (int k = 0; k < cut; k++) send_item(frame_byte(next_frame_byte()));
               sent += cut + 1;
            end
         endcase
      end
   endtask

   initial begin
      vadpcm_pkg::req_data_type it;
      mismatches = 0;
      steady = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = vadpcm_pkg::CSR_PREDICTOR_COUNT;
      csr_data = '0;
      rsp_ready = 1'b0;
      cfg_count = 5'd1;
      cfg_half = 1'b0;
      hist_older = 0;
      hist_newer = 0;
      foreach (residuals[k]) residuals[k] = 0;
      tail_six = 0;
      frame_pos = 0;
      frame_scale = 0;
      frame_pred = 0;
      foreach (coef_rom[k]) coef_rom[k] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load the coefficient sets that headers may pick; mostly moderate
      // coefficients, with the extremes sprinkled in
      steady = 1'b1;
      for (int a = 0; a < LOADED_PREDICTORS * 16; a++) begin
         it = '0;
         it.kind = vadpcm_pkg::KIND_COEF_WRITE;
         it.coef_index = 8'(a);
         case ($urandom_range(0, 9))
            0: it.coef_value = 16'sh7FFF;
            1: it.coef_value = -16'sh8000;
            2: it.coef_value = 16'($urandom);
            default: it.coef_value = 16'($urandom_range(0, 4095)) - 16'sd2048;
         endcase
         send_item(it);
      end
      steady = 1'b0;

      // Directed: silent frame decodes to zeros, then extreme headers/codes
      add_row(vadpcm_pkg::KIND_START, 8'h00);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'h00);
      for (int k = 0; k < 8; k++)
         add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'h00, 1, 16'sd0, 1'b0);
      add_row(vadpcm_pkg::KIND_UNUSED, 8'hFF);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'hFF);   // largest scale, predictor folds
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'h77);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'h88);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'hFF);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'h80);
      add_row(vadpcm_pkg::KIND_COEF_WRITE, 8'h00, 0, 0, 0, 8'hFF, -16'sh8000);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'h08);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'h7F);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'hF7);
      add_row(vadpcm_pkg::KIND_START, 8'h00);        // mid-frame restart
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'hC0);
      add_row(vadpcm_pkg::KIND_FRAME_BYTE, 8'h70);
      foreach (directed_rows[r]) begin
         it = '0;
         it.kind = directed_rows[r].kind;
         it.data_byte = directed_rows[r].data_byte;
         it.coef_index = directed_rows[r].coef_index;
         it.coef_value = directed_rows[r].coef_value;
         send_item(it, directed_rows[r].typed,
                   directed_rows[r].exp_sample, directed_rows[r].exp_clipped);
      end

      // Register settings: extremes, out-of-range counts and both modes
      write_reg(vadpcm_pkg::CSR_PREDICTOR_COUNT, 5'd16);
      random_phase(18);
      write_reg(vadpcm_pkg::CSR_HALF_MODE, 5'd1);
      steady = 1'b1;
      random_phase(18);
      steady = 1'b0;
      write_reg(vadpcm_pkg::CSR_PREDICTOR_COUNT, 5'd0);
      random_phase(14);
      wait_drained();               // hold off until every sample is back
      random_phase(8);
      write_reg(vadpcm_pkg::CSR_HALF_MODE, 5'd0);
      write_reg(vadpcm_pkg::CSR_PREDICTOR_COUNT, 5'd31);
      random_phase(18);
      write_reg(vadpcm_pkg::CSR_PREDICTOR_COUNT, 5'd5);
      write_reg(vadpcm_pkg::CSR_HALF_MODE, 5'd1);
      random_phase(18);
      write_reg(vadpcm_pkg::CSR_PREDICTOR_COUNT, 5'd1);
      write_reg(vadpcm_pkg::CSR_HALF_MODE, 5'd0);
      random_phase(18);

      wait_drained();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
